[rtl/core/tlc_pkg.sv]
`default_nettype none
package tlc_pkg;

	typedef enum logic [2:0] {
		MODE_INIT       = 3'd0,
		MODE_RG         = 3'd1,
		MODE_RA         = 3'd2,
		MODE_GR         = 3'd3,
		MODE_AR         = 3'd4,
		MODE_MAN_RED    = 3'd5,
		MODE_MAN_AMBER  = 3'd6,
		MODE_MAN_GREEN  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		BTN_PED  = 2'd0,
		BTN_MODE = 2'd1,
		BTN_INC  = 2'd2,
		BTN_BAL  = 2'd3
	} button_t;

	typedef enum logic [1:0] {
		DUR_RED   = 2'd0,
		DUR_AMBER = 2'd1,
		DUR_GREEN = 2'd2
	} dur_t;

	localparam int SEC_W     = 7;
	localparam int BUZ_W     = 16;
	localparam int DIV_STEPS = SEC_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic       KIND_TICK  = 1'b0;
	localparam logic [2:0] LAMP_OFF   = 3'b000;
	localparam logic [2:0] LAMP_RED   = 3'b001;
	localparam logic [2:0] LAMP_AMBER = 3'b010;
	localparam logic [2:0] LAMP_GREEN = 3'b100;

	localparam logic [1:0] PED_NONE  = 2'd0;
	localparam logic [1:0] PED_RED   = 2'd1;
	localparam logic [1:0] PED_GREEN = 2'd2;

	localparam logic [SEC_W-1:0] BUZ_WINDOW = 7'd5;
	localparam logic [SEC_W-1:0] NUM_AMBER  = 7'd3;
	localparam logic [SEC_W-1:0] NUM_RED    = 7'd2;
	localparam logic [SEC_W-1:0] NUM_GREEN  = 7'd4;

	// x/5 = (x*205)>>10 and x/3 = (x*171)>>9 for 7-bit x
	localparam logic [7:0] DIV5_MUL = 8'd205;
	localparam int         DIV5_SH  = 10;
	localparam logic [7:0] DIV3_MUL = 8'd171;
	localparam int         DIV3_SH  = 9;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic bal;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} sts_t;

	function automatic logic [5:0] lamps_for(input mode_t m, input logic blink);
		logic [2:0] c;
		c = LAMP_OFF;
		unique case (m)
			MODE_RG:        return {LAMP_RED, LAMP_GREEN};
			MODE_RA:        return {LAMP_RED, LAMP_AMBER};
			MODE_GR:        return {LAMP_GREEN, LAMP_RED};
			MODE_AR:        return {LAMP_AMBER, LAMP_RED};
			MODE_MAN_RED:   c = blink ? LAMP_RED : LAMP_OFF;
			MODE_MAN_AMBER: c = blink ? LAMP_AMBER : LAMP_OFF;
			MODE_MAN_GREEN: c = blink ? LAMP_GREEN : LAMP_OFF;
			default:        c = LAMP_OFF;
		endcase
		return {c, c};
	endfunction

endpackage
`default_nettype wire

[rtl/core/tlc_ctrl.sv]
`default_nettype none
module tlc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire tlc_pkg::sts_t sts,
	output tlc_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_BAL, S_EMIT} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit_ok;

	assign emit_ok   = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.exec     = (state_q == S_EXEC);
		cmd.div_step = (state_q == S_DIV);
		cmd.bal      = (state_q == S_BAL);
		cmd.emit     = (state_q == S_EMIT) && emit_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= sts.need_div ? S_DIV : S_EMIT;
				S_DIV:  if (sts.div_done) state_q <= S_BAL;
				S_BAL:  state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_ok) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_EXEC)
		else $error("accepted transaction did not start execution");
	a_bal_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BAL |-> $past(state_q) == S_DIV)
		else $error("balance apply without division");
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q && state_q == S_IDLE)
		else $error("emitted result not presented");

endmodule
`default_nettype wire

[rtl/core/tlc_dpath.sv]
`default_nettype none
module tlc_dpath #(
	parameter int TICKS_PER_SECOND = 100,
	parameter int BLINK_TICKS      = 25,
	parameter int MAX_COUNT        = 99
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tlc_pkg::cmd_t             cmd,
	output tlc_pkg::sts_t                  sts,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [tlc_pkg::SEC_W-1:0] cfg_data,
	input  wire logic                      kind,
	input  wire logic [1:0]                button,
	output logic [2:0]                     lamps_road_one,
	output logic [2:0]                     lamps_road_two,
	output logic [tlc_pkg::SEC_W-1:0]      count_road_one,
	output logic [tlc_pkg::SEC_W-1:0]      count_road_two,
	output logic [2:0]                     mode,
	output logic [1:0]                     pedestrian_state,
	output logic [tlc_pkg::BUZ_W-1:0]      buzzer_level
);

	localparam int W  = tlc_pkg::SEC_W;
	localparam int PW = $clog2(127 * TICKS_PER_SECOND + 1);
	localparam int SW = $clog2(TICKS_PER_SECOND + 1);
	localparam int BW = $clog2(BLINK_TICKS + 1);
	localparam logic [PW-1:0] TPS_P = PW'(TICKS_PER_SECOND);
	localparam logic [SW-1:0] TPS_S = SW'(TICKS_PER_SECOND);
	localparam logic [BW-1:0] BLK   = BW'(BLINK_TICKS);
	localparam logic [W-1:0]  MAXC  = W'(MAX_COUNT);

	function automatic logic [W-1:0] sat(input logic [2*W-1:0] v);
		return (v > (2*W)'(MAX_COUNT)) ? MAXC : v[W-1:0];
	endfunction

	logic [W-1:0] red_init_q, amb_init_q, grn_init_q;
	logic [W-1:0] red_q, amb_q, grn_q, c1_q, c2_q;
	tlc_pkg::mode_t mode_q;
	logic [PW-1:0] ph_q;
	logic [SW-1:0] sc_q;
	logic [BW-1:0] bt_q;
	logic          blink_q;
	logic [1:0]    ped_q;
	logic [tlc_pkg::BUZ_W-1:0] buz_q;
	logic          kind_q;
	logic [1:0]    btn_q;

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q, dd_q, dn_q;
	tlc_pkg::dur_t tgt_q;
	logic [tlc_pkg::CNT_W-1:0] dcnt_q;

	tlc_pkg::mode_t mode_n;
	logic [W-1:0]  red_n, amb_n, grn_n, c1_n, c2_n, r, a, g, dn, dd, q;
	logic [PW-1:0] ph_n;
	logic [SW-1:0] sc_n;
	logic [BW-1:0] bt_n;
	logic          blink_n, need, press;
	logic [1:0]    ped_n;
	logic [tlc_pkg::BUZ_W-1:0] buz_n;
	logic [W:0]    inc;
	logic [2:0]    diff;
	logic signed [18:0] bz;
	logic [14:0]   prod;
	tlc_pkg::dur_t tgt;
	logic [W:0]    trial;

	always_comb begin
		mode_n = mode_q; red_n = red_q; amb_n = amb_q; grn_n = grn_q;
		c1_n = c1_q; c2_n = c2_q; ph_n = ph_q; sc_n = sc_q; bt_n = bt_q;
		blink_n = blink_q; ped_n = ped_q; buz_n = buz_q;
		need = 1'b0; dn = '0; dd = '0; tgt = tlc_pkg::DUR_RED;
		r = red_q; a = amb_q; g = grn_q;
		inc = '0; diff = '0; bz = '0; prod = '0; q = '0;
		press = (kind_q != tlc_pkg::KIND_TICK);
		if (!press) begin
			if (ph_n != '0) ph_n = ph_n - 1'b1;
			if (sc_n != '0) sc_n = sc_n - 1'b1;
			if (bt_n != '0) bt_n = bt_n - 1'b1;
		end
		unique case (mode_q) inside
			tlc_pkg::MODE_INIT: begin
				red_n = red_init_q; amb_n = amb_init_q; grn_n = grn_init_q;
				mode_n = tlc_pkg::MODE_RG;
				ph_n = PW'(grn_init_q) * TPS_P; sc_n = TPS_S;
				c1_n = red_init_q; c2_n = grn_init_q;
			end
			tlc_pkg::MODE_RG, tlc_pkg::MODE_RA, tlc_pkg::MODE_GR, tlc_pkg::MODE_AR: begin
				if (ph_n == '0) begin
					sc_n = TPS_S;
					unique case (mode_q) inside
						tlc_pkg::MODE_RG, tlc_pkg::MODE_GR: begin
							mode_n = (mode_q == tlc_pkg::MODE_RG) ? tlc_pkg::MODE_RA
								: tlc_pkg::MODE_AR;
							ph_n = PW'(amb_q) * TPS_P; c1_n = amb_q; c2_n = amb_q;
						end
						tlc_pkg::MODE_RA: begin
							mode_n = tlc_pkg::MODE_GR;
							ph_n = PW'(grn_q) * TPS_P; c1_n = grn_q; c2_n = red_q;
							if (ped_n == tlc_pkg::PED_RED) ped_n = tlc_pkg::PED_GREEN;
						end
						default: begin
							mode_n = tlc_pkg::MODE_RG;
							ph_n = PW'(grn_q) * TPS_P; c1_n = red_q; c2_n = grn_q;
							if (ped_n == tlc_pkg::PED_GREEN) ped_n = tlc_pkg::PED_RED;
						end
					endcase
				end
				if (mode_q == tlc_pkg::MODE_AR) begin
					if (amb_q >= tlc_pkg::BUZ_WINDOW) begin
						if (c1_n <= tlc_pkg::BUZ_WINDOW) begin
							diff = 3'(tlc_pkg::BUZ_WINDOW - c1_n);
							buz_n = {4'd0, diff, 9'd0};
						end
					end else begin
						bz = $signed({3'b000, buz_q})
							+ ((19'sd5 - $signed({12'd0, c1_n})) <<< 8);
						if (bz < 0) buz_n = '0;
						else if (bz > 19'sd65535) buz_n = '1;
						else buz_n = bz[15:0];
					end
				end
				if (sc_n == '0) begin
					sc_n = TPS_S;
					if (c1_n != '0) c1_n = c1_n - 1'b1;
					if (c2_n != '0) c2_n = c2_n - 1'b1;
				end
				if (mode_q == tlc_pkg::MODE_GR && amb_q < tlc_pkg::BUZ_WINDOW
						&& c1_n <= tlc_pkg::BUZ_WINDOW - amb_q) begin
					diff = 3'(tlc_pkg::BUZ_WINDOW - amb_q - c1_n);
					buz_n = {4'd0, diff, 9'd0};
				end
				if (press) begin
					if (btn_q == tlc_pkg::BTN_MODE) begin
						mode_n = tlc_pkg::MODE_MAN_RED; c1_n = red_q; c2_n = tlc_pkg::NUM_RED;
						blink_n = 1'b0; bt_n = BLK;
					end else if (btn_q == tlc_pkg::BTN_PED) begin
						ped_n = (mode_q == tlc_pkg::MODE_RG || mode_q == tlc_pkg::MODE_RA)
							? tlc_pkg::PED_RED : tlc_pkg::PED_GREEN;
					end
				end
			end
			default: begin
				if (bt_n == '0) begin
					bt_n = BLK; blink_n = !blink_q;
				end
				if (press) begin
					unique case (btn_q)
						tlc_pkg::BTN_INC: begin
							inc = {1'b0, c1_q} + 1'b1;
							c1_n = (inc > (W+1)'(MAX_COUNT)) ? W'(1) : inc[W-1:0];
						end
						tlc_pkg::BTN_BAL: begin
							if (mode_q == tlc_pkg::MODE_MAN_RED) r = c1_q;
							else if (mode_q == tlc_pkg::MODE_MAN_AMBER) a = c1_q;
							else g = c1_q;
							if (r > red_q) begin
								need = (red_q != '0); dn = r; dd = red_q; tgt = tlc_pkg::DUR_RED;
							end else if (a > amb_q) begin
								need = (amb_q != '0); dn = a; dd = amb_q;
								tgt = tlc_pkg::DUR_AMBER;
							end else if (g > grn_q) begin
								need = (grn_q != '0); dn = g; dd = grn_q;
								tgt = tlc_pkg::DUR_GREEN;
							end else if (r < red_q) begin
								prod = 15'(r) * 15'(tlc_pkg::DIV5_MUL);
								q = W'(prod >> tlc_pkg::DIV5_SH);
								amb_n = sat((2*W)'(q) * 14'd2);
								grn_n = sat((2*W)'(q) * 14'd3);
								red_n = sat((2*W)'(r));
							end else if (a < amb_q) begin
								q = a >> 1;
								red_n = sat((2*W)'(q) * 14'd5);
								grn_n = sat((2*W)'(q) * 14'd3);
								amb_n = sat((2*W)'(a));
							end else if (g < grn_q) begin
								prod = 15'(g) * 15'(tlc_pkg::DIV3_MUL);
								q = W'(prod >> tlc_pkg::DIV3_SH);
								red_n = sat((2*W)'(q) * 14'd5);
								amb_n = sat((2*W)'(q) * 14'd2);
								grn_n = sat((2*W)'(g));
							end
						end
						tlc_pkg::BTN_MODE: begin
							blink_n = 1'b0; bt_n = BLK;
							if (mode_q == tlc_pkg::MODE_MAN_RED) begin
								mode_n = tlc_pkg::MODE_MAN_AMBER; c1_n = amb_q;
								c2_n = tlc_pkg::NUM_AMBER;
							end else if (mode_q == tlc_pkg::MODE_MAN_AMBER) begin
								mode_n = tlc_pkg::MODE_MAN_GREEN; c1_n = grn_q;
								c2_n = tlc_pkg::NUM_GREEN;
							end else begin
								mode_n = tlc_pkg::MODE_RG;
								ph_n = PW'(grn_q) * TPS_P; sc_n = TPS_S;
								c1_n = red_q; c2_n = grn_q;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	// keep blink state when leaving manual green for the normal cycle
	logic          blink_f;
	logic [BW-1:0] bt_f;
	always_comb begin
		blink_f = blink_n;
		bt_f    = bt_n;
		if (mode_q == tlc_pkg::MODE_MAN_GREEN && mode_n == tlc_pkg::MODE_RG) begin
			blink_f = (bt_q == '0 || (bt_q == BW'(1) && !press)) ? !blink_q : blink_q;
			bt_f    = (bt_q == '0 || (bt_q == BW'(1) && !press)) ? BLK
				: (press ? bt_q : bt_q - 1'b1);
		end
	end

	assign sts.need_div = need;
	assign sts.div_done = (dcnt_q == tlc_pkg::CNT_W'(tlc_pkg::DIV_STEPS - 1));
	assign trial        = {rem_q[W-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_init_q <= W'(5); amb_init_q <= W'(2); grn_init_q <= W'(3);
			red_q <= W'(5); amb_q <= W'(2); grn_q <= W'(3);
			mode_q <= tlc_pkg::MODE_INIT;
			c1_q <= '0; c2_q <= '0; ph_q <= '0; sc_q <= '0; bt_q <= '0;
			blink_q <= 1'b0; ped_q <= tlc_pkg::PED_NONE; buz_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tlc_pkg::DUR_RED:   red_init_q <= cfg_data;
					tlc_pkg::DUR_AMBER: amb_init_q <= cfg_data;
					tlc_pkg::DUR_GREEN: grn_init_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.exec) begin
				mode_q <= mode_n; red_q <= red_n; amb_q <= amb_n; grn_q <= grn_n;
				c1_q <= c1_n; c2_q <= c2_n; ph_q <= ph_n; sc_q <= sc_n;
				bt_q <= bt_f; blink_q <= blink_f; ped_q <= ped_n; buz_q <= buz_n;
				dcnt_q <= '0;
			end
			if (cmd.div_step) dcnt_q <= dcnt_q + 1'b1;
			if (cmd.bal) begin
				red_q <= (tgt_q == tlc_pkg::DUR_RED) ? sat((2*W)'(dn_q))
					: sat((2*W)'(red_q) * (2*W)'(quo_q));
				amb_q <= (tgt_q == tlc_pkg::DUR_AMBER) ? sat((2*W)'(dn_q))
					: sat((2*W)'(amb_q) * (2*W)'(quo_q));
				grn_q <= (tgt_q == tlc_pkg::DUR_GREEN) ? sat((2*W)'(dn_q))
					: sat((2*W)'(grn_q) * (2*W)'(quo_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			btn_q  <= button;
		end
		if (cmd.exec) begin
			rem_q <= '0; quo_q <= dn; dn_q <= dn; dd_q <= dd; tgt_q <= tgt;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, dd_q}) begin
				rem_q <= trial - {1'b0, dd_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			{lamps_road_one, lamps_road_two} <= tlc_pkg::lamps_for(mode_q, blink_q);
			count_road_one   <= c1_q;
			count_road_two   <= c2_q;
			mode             <= mode_q;
			pedestrian_state <= ped_q;
			buzzer_level     <= buz_q;
		end
	end

endmodule
`default_nettype wire

[rtl/core/traffic_light_controller_manual_set_core.sv]
`default_nettype none
// Two-road traffic light controller with manual duration setting.
// Input channel (in_valid/in_stall, kind, button): one transaction per timer
// tick (kind 0) or button press (kind 1). Output channel (out_valid/out_stall)
// returns exactly one result transaction per input transaction, in order.
// Configuration: cfg_we/cfg_index/cfg_data write the red, amber and green
// start durations (index 0..2); they are loaded when the block leaves init.
// Timing: a transaction is executed in the cycle after acceptance, and its
// result is then registered into the output register by the emit state. A
// balance press that splits by ratio first runs the 7-step serial divider.
// The next transaction is accepted once the controller is back in idle, even
// while the previous result still waits in the output register.
// Stall: a held result stays on the output ports; the controller waits in its
// emit state until the output register frees, stalling the input meanwhile.
// Reset: asynchronous, active low; the block starts in init mode with
// durations 5/2/3 s, all timers expired and the buzzer silent.
module traffic_light_controller_manual_set_core #(
	parameter int TICKS_PER_SECOND = 100,
	parameter int BLINK_TICKS      = 25,
	parameter int MAX_COUNT        = 99
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [1:0]  button,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       lamps_road_one,
	output logic [2:0]       lamps_road_two,
	output logic [6:0]       count_road_one,
	output logic [6:0]       count_road_two,
	output logic [2:0]       mode,
	output logic [1:0]       pedestrian_state,
	output logic [15:0]      buzzer_level
);

	tlc_pkg::cmd_t cmd;
	tlc_pkg::sts_t sts;

	tlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlc_dpath #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.BLINK_TICKS      (BLINK_TICKS),
		.MAX_COUNT        (MAX_COUNT)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.kind             (kind),
		.button           (button),
		.lamps_road_one   (lamps_road_one),
		.lamps_road_two   (lamps_road_two),
		.count_road_one   (count_road_one),
		.count_road_two   (count_road_two),
		.mode             (mode),
		.pedestrian_state (pedestrian_state),
		.buzzer_level     (buzzer_level)
	);

endmodule
`default_nettype wire
